FILE: rtl/core/ccad_pkg.sv
// ----------------------------------------------------------------------------
// ccad_pkg
// Shared widths, register indexes and reset values of the center-crop
// area-average downscaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ccad_pkg;

    localparam int CFG_DIM_W   = 14;
    localparam int CFG_OUT_W   = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int PIX_W       = 8;
    localparam int COORD_W     = 8;
    localparam int AREA_W      = 2 * CFG_DIM_W;
    localparam int SUM_W       = AREA_W + PIX_W;
    localparam int CMP_W       = 11;

    localparam int DEF_MAX_DIM = 8192;
    localparam int DEF_MAX_OUT = 256;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SIZE   = 2'd2;

    localparam logic [CFG_DIM_W-1:0] RST_SRC_WIDTH  = 14'd64;
    localparam logic [CFG_DIM_W-1:0] RST_SRC_HEIGHT = 14'd64;
    localparam logic [CFG_OUT_W-1:0] RST_OUT_SIZE   = 9'd64;

    typedef logic [SUM_W-1:0] sum_t;

endpackage
`default_nettype wire

FILE: rtl/core/ccad_step_div.sv
// ----------------------------------------------------------------------------
// ccad_step_div
// Bit-serial divider for the window step: crop side over thumbnail size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ccad_step_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [ccad_pkg::CFG_DIM_W-1:0]  dividend,
    input  wire logic [ccad_pkg::CFG_OUT_W-1:0]  divisor,
    output logic                                 busy,
    output logic                                 done,
    output logic [ccad_pkg::CFG_DIM_W-1:0]       quot,
    output logic [ccad_pkg::CFG_OUT_W-1:0]       rem
);
    import ccad_pkg::*;

    localparam int CNT_W = $clog2(CFG_DIM_W + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CFG_DIM_W-1:0]   dvd_reg;
    logic [CFG_DIM_W-1:0]   quot_reg;
    logic [CFG_OUT_W:0]     rem_reg;
    logic [CFG_OUT_W-1:0]   dvs_reg;
    logic [CFG_OUT_W:0]     trial;
    logic                   fits;

    // shift in next dividend bit and test against divisor
    always_comb begin
        trial = {rem_reg[CFG_OUT_W-1:0], dvd_reg[CFG_DIM_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(CFG_DIM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg  <= {dvd_reg[CFG_DIM_W-2:0], 1'b0};
            rem_reg  <= fits ? (trial - {1'b0, dvs_reg}) : trial;
            quot_reg <= {quot_reg[CFG_DIM_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg[CFG_OUT_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/ccad_avg_div.sv
// ----------------------------------------------------------------------------
// ccad_avg_div
// Three-channel restoring divider: window sums over window area, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ccad_avg_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire ccad_pkg::sum_t                sum_red,
    input  wire ccad_pkg::sum_t                sum_green,
    input  wire ccad_pkg::sum_t                sum_blue,
    input  wire logic [ccad_pkg::AREA_W-1:0]   area,
    output logic                               busy,
    output logic [ccad_pkg::PIX_W-1:0]         avg_red,
    output logic [ccad_pkg::PIX_W-1:0]         avg_green,
    output logic [ccad_pkg::PIX_W-1:0]         avg_blue
);
    import ccad_pkg::*;

    localparam int CNT_W = $clog2(PIX_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    sum_t             dvs_reg;
    sum_t             rem_reg [3];
    logic [PIX_W-1:0] q_reg   [3];
    logic [2:0]       fits;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fits[c] = rem_reg[c] >= dvs_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(PIX_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // subtract shifted area where it fits, then halve it
    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg    <= SUM_W'(area) << (PIX_W - 1);
            rem_reg[0] <= sum_red;
            rem_reg[1] <= sum_green;
            rem_reg[2] <= sum_blue;
            for (int c = 0; c < 3; c++) begin
                q_reg[c] <= '0;
            end
        end else if (busy_reg) begin
            dvs_reg <= dvs_reg >> 1;
            for (int c = 0; c < 3; c++) begin
                if (fits[c]) begin
                    rem_reg[c] <= rem_reg[c] - dvs_reg;
                end
                q_reg[c] <= {q_reg[c][PIX_W-2:0], fits[c]};
            end
        end
    end

    assign busy      = busy_reg;
    assign avg_red   = q_reg[0];
    assign avg_green = q_reg[1];
    assign avg_blue  = q_reg[2];

endmodule
`default_nettype wire

FILE: rtl/core/center_crop_area_downscale_unit.sv
// ----------------------------------------------------------------------------
// center_crop_area_downscale_unit
// Center-crop area-average thumbnail generator for an RGB raster stream.
// ----------------------------------------------------------------------------
// Source pixels enter on the s_ stream one beat each, in raster order; the
// block keeps the centered square crop and averages it into out_size x
// out_size windows, emitting one m_ beat per finished window (m_tlast on the
// final one of the frame). Registers are to be written over the cfg_ channel
// while the block is idle, which the block does not enforce; any write to a
// listed register restarts the frame. Per-window-column running sums live in
// a one-port synchronous RAM. An in-crop pixel is accepted with the RAM read,
// then added and written back. A pixel that closes a window then passes the
// divider load, the 8-step serial divider and the output register load; the
// input stalls during that time, and longer while an earlier result still
// waits for m_tready. Pixels outside the crop, or under a bad configuration,
// are accepted without entering the sequencer. After reset and after each
// write to a listed register, the window step divider runs while s_tready is
// held low. A finished result waits in the output register; the next pixel is
// still accepted, and only a following window result waits for m_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module center_crop_area_downscale_unit #(
    parameter int MAX_DIM = ccad_pkg::DEF_MAX_DIM,
    parameter int MAX_OUT = ccad_pkg::DEF_MAX_OUT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // cfg_data: register value (low bits used)
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ccad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ccad_pkg::CFG_DIM_W-1:0] cfg_data,
    // s_tdata: in_red [7:0], in_green [15:8], in_blue [23:16]
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [23:0]                    s_tdata,
    // m_tdata: out_red [7:0], out_green [15:8], out_blue [23:16],
    //          out_column [31:24], out_row [39:32]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [39:0]                         m_tdata,
    output logic                                m_tlast
);
    import ccad_pkg::*;

    localparam int CW  = $clog2(MAX_DIM);
    localparam int WW  = $clog2(MAX_OUT);
    localparam int DW  = CFG_DIM_W;
    localparam int OW  = CFG_OUT_W;
    localparam int MW  = 3 * SUM_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    // configuration
    logic [DW-1:0] width_reg, height_reg;
    logic [OW-1:0] outsz_reg;
    logic          cfg_wr, restart;
    logic          step_go_reg;

    // position and window tracking
    logic [CW-1:0] col_reg, row_reg;
    logic [WW-1:0] wc_reg, wr_reg;
    logic [DW-1:0] xs_reg, xe_reg, ys_reg, ye_reg;
    logic [OW-1:0] xr_reg, yr_reg;

    // pixel in flight
    logic [1:0]       st_reg;
    logic [PIX_W-1:0] pix_reg [3];
    logic             emit_reg, last_reg;
    logic [WW-1:0]    wc_p_reg, wr_p_reg;
    logic [DW-1:0]    xw_reg, yw_reg;
    logic [AREA_W-1:0] area_reg;
    sum_t             sum_reg [3];

    // sum memory
    logic [MW-1:0]      mem [MAX_OUT];
    logic [MW-1:0]      mem_q;
    logic [MAX_OUT-1:0] vld_reg;
    logic               mem_we;
    logic [MW-1:0]      mem_wd;
    sum_t               acc [3];

    // output register
    logic        m_valid_reg, m_last_reg;
    logic [39:0] m_data_reg;

    // step divider
    logic          sd_busy, sd_done;
    logic [DW-1:0] step_q;
    logic [OW-1:0] step_r;

    // average divider
    logic             ad_busy, ad_start;
    logic [PIX_W-1:0] avg_r, avg_g, avg_b;

    // derived geometry
    logic [DW-1:0] side, left, top;
    logic          cfg_ok;
    logic [DW:0]   colx, rowx, cx1, cy1;
    logic          in_crop, col_end, side_end, row_end, src_row_end, frame_end;
    logic          accept, last_cmp;
    logic [DW-1:0] xe_adv, ye_adv;
    logic [OW-1:0] xr_adv, yr_adv;
    logic [OW:0]   xr_sum, yr_sum;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && (cfg_index == REG_SRC_WIDTH ||
                       cfg_index == REG_SRC_HEIGHT || cfg_index == REG_OUT_SIZE);
    assign restart   = !aresetn || cfg_wr;

    // hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_SRC_WIDTH;
            height_reg <= RST_SRC_HEIGHT;
            outsz_reg  <= RST_OUT_SIZE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SRC_WIDTH:  width_reg  <= cfg_data;
                REG_SRC_HEIGHT: height_reg <= cfg_data;
                REG_OUT_SIZE:   outsz_reg  <= cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    // geometry and legality of the setup
    always_comb begin
        side   = (width_reg < height_reg) ? width_reg : height_reg;
        left   = (width_reg - side) >> 1;
        top    = (height_reg - side) >> 1;
        cfg_ok = width_reg != '0 && 32'(width_reg) <= MAX_DIM &&
                 height_reg != '0 && 32'(height_reg) <= MAX_DIM &&
                 outsz_reg != '0 && 32'(outsz_reg) <= MAX_OUT &&
                 DW'(outsz_reg) <= side;
    end

    // launch step divider in the cycle after a restart
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_go_reg <= 1'b1;
        end else begin
            step_go_reg <= cfg_wr;
        end
    end

    ccad_step_div u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (step_go_reg),
        .dividend (side),
        .divisor  (outsz_reg),
        .busy     (sd_busy),
        .done     (sd_done),
        .quot     (step_q),
        .rem      (step_r)
    );

    // hold the input until the window edges are loaded and the sequencer is idle
    assign accept = s_tvalid && s_tready;
    assign s_tready = st_reg == ST_IDLE && !sd_busy && !sd_done && !step_go_reg;

    // position tests for the incoming pixel
    always_comb begin
        colx    = (DW + 1)'(col_reg);
        rowx    = (DW + 1)'(row_reg);
        in_crop = colx >= {1'b0, left} && colx < {1'b0, left} + {1'b0, side} &&
                  rowx >= {1'b0, top} && rowx < {1'b0, top} + {1'b0, side};
        cx1      = colx - {1'b0, left} + 1'b1;
        cy1      = rowx - {1'b0, top} + 1'b1;
        col_end  = cx1 == {1'b0, xe_reg};
        side_end = cx1 == {1'b0, side};
        row_end  = cy1 == {1'b0, ye_reg};
        src_row_end = colx + 1'b1 >= {1'b0, width_reg};
        frame_end   = src_row_end && rowx + 1'b1 >= {1'b0, height_reg};
        last_cmp = CMP_W'(wc_reg) + 1'b1 == CMP_W'(outsz_reg) &&
                   CMP_W'(wr_reg) + 1'b1 == CMP_W'(outsz_reg);
        // next window edges: add step quotient, carry from remainder
        xr_sum = {1'b0, xr_reg} + {1'b0, step_r};
        yr_sum = {1'b0, yr_reg} + {1'b0, step_r};
        if (xr_sum >= {1'b0, outsz_reg}) begin
            xe_adv = xe_reg + step_q + 1'b1;
            xr_adv = OW'(xr_sum - {1'b0, outsz_reg});
        end else begin
            xe_adv = xe_reg + step_q;
            xr_adv = OW'(xr_sum);
        end
        if (yr_sum >= {1'b0, outsz_reg}) begin
            ye_adv = ye_reg + step_q + 1'b1;
            yr_adv = OW'(yr_sum - {1'b0, outsz_reg});
        end else begin
            ye_adv = ye_reg + step_q;
            yr_adv = OW'(yr_sum);
        end
    end

    // advance source and window counters
    always_ff @(posedge aclk) begin
        if (restart) begin
            col_reg <= '0;
            row_reg <= '0;
            wc_reg  <= '0;
            wr_reg  <= '0;
        end else if (sd_done) begin
            xs_reg <= '0;
            xe_reg <= step_q;
            xr_reg <= step_r;
            ys_reg <= '0;
            ye_reg <= step_q;
            yr_reg <= step_r;
        end else if (accept && cfg_ok) begin
            if (in_crop) begin
                if (col_end) begin
                    wc_reg <= wc_reg + 1'b1;
                    xs_reg <= xe_reg;
                    xe_reg <= xe_adv;
                    xr_reg <= xr_adv;
                end
                if (side_end) begin
                    wc_reg <= '0;
                    xs_reg <= '0;
                    xe_reg <= step_q;
                    xr_reg <= step_r;
                    if (row_end) begin
                        wr_reg <= wr_reg + 1'b1;
                        ys_reg <= ye_reg;
                        ye_reg <= ye_adv;
                        yr_reg <= yr_adv;
                    end
                end
            end
            if (src_row_end) begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
                if (frame_end) begin
                    row_reg <= '0;
                    wc_reg  <= '0;
                    wr_reg  <= '0;
                    xs_reg  <= '0;
                    xe_reg  <= step_q;
                    xr_reg  <= step_r;
                    ys_reg  <= '0;
                    ye_reg  <= step_q;
                    yr_reg  <= step_r;
                end
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // capture the pixel in flight
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg[0] <= s_tdata[7:0];
            pix_reg[1] <= s_tdata[15:8];
            pix_reg[2] <= s_tdata[23:16];
            emit_reg   <= col_end && row_end;
            last_reg   <= last_cmp;
            wc_p_reg   <= wc_reg;
            wr_p_reg   <= wr_reg;
            xw_reg     <= xe_reg - xs_reg;
            yw_reg     <= ye_reg - ys_reg;
        end
    end

    // sum RAM: read on accept, write back in the add cycle
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c] = (vld_reg[wc_p_reg] ? mem_q[c*SUM_W +: SUM_W] : '0) +
                     SUM_W'(pix_reg[c]);
        end
        mem_wd = {acc[2], acc[1], acc[0]};
        mem_we = st_reg == ST_ACC && !emit_reg;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mem_q <= mem[wc_reg];
        end
        if (mem_we) begin
            mem[wc_p_reg] <= mem_wd;
        end
    end

    // entry valid bits: clear on restart and when a window closes
    always_ff @(posedge aclk) begin
        if (restart) begin
            vld_reg <= '0;
        end else if (st_reg == ST_ACC) begin
            vld_reg[wc_p_reg] <= !emit_reg;
        end
    end

    // latch finished sums and window area
    always_ff @(posedge aclk) begin
        if (st_reg == ST_ACC && emit_reg) begin
            for (int c = 0; c < 3; c++) begin
                sum_reg[c] <= acc[c];
            end
            area_reg <= AREA_W'(xw_reg) * AREA_W'(yw_reg);
        end
    end

    assign ad_start = st_reg == ST_LOAD;

    ccad_avg_div u_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ad_start),
        .sum_red   (sum_reg[0]),
        .sum_green (sum_reg[1]),
        .sum_blue  (sum_reg[2]),
        .area      (area_reg),
        .busy      (ad_busy),
        .avg_red   (avg_r),
        .avg_green (avg_g),
        .avg_blue  (avg_b)
    );

    // pixel sequencer
    always_ff @(posedge aclk) begin
        if (restart) begin
            st_reg <= ST_IDLE;
        end else begin
            case (st_reg)
                ST_IDLE: begin
                    if (accept && cfg_ok && in_crop) begin
                        st_reg <= ST_ACC;
                    end
                end
                ST_ACC:  st_reg <= emit_reg ? ST_LOAD : ST_IDLE;
                ST_LOAD: st_reg <= ST_DIV;
                ST_DIV: begin
                    if (!ad_busy && (!m_valid_reg || m_tready)) begin
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // output register: load finished average, drop on beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_reg == ST_DIV && !ad_busy && (!m_valid_reg || m_tready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_DIV && !ad_busy && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {COORD_W'(wr_p_reg), COORD_W'(wc_p_reg), avg_b, avg_g, avg_r};
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire
